@@ rtl/b62_pkg.sv @@
// shared types, constants and the alphabet lookup for the base62 decoder
`default_nettype none

package b62_pkg;

    localparam int MAX_CHARS    = 32;
    localparam int IDX_W        = $clog2(MAX_CHARS);
    localparam int CNT_W        = $clog2(MAX_CHARS + 1);
    localparam int TOT_W        = CNT_W + 1;
    localparam int RESULT_LIMIT = 32;
    localparam int CAP_W        = 6;
    localparam int RADIX        = 62;
    localparam int CARRY_W      = 6;
    localparam int MAC_W        = 8 + CARRY_W;

    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;

    localparam logic [5:0] UPPER_BASE = 6'd10;
    localparam logic [5:0] LOWER_BASE = 6'd36;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHECK,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_INVALID  = 2'd1,
        STAT_CAPACITY = 2'd2,
        STAT_TOO_LONG = 2'd3
    } status_t;

    typedef struct packed {
        logic       is_digit;
        logic [5:0] value;
    } digit_t;

    // map one character code to its digit 0..61
    function automatic digit_t char_to_digit(input logic [7:0] code);
        digit_t d;
        d.is_digit = 1'b1;
        d.value    = 6'd0;
        if (code inside {[CHAR_ZERO:CHAR_NINE]})
        begin
            d.value = 6'(code - CHAR_ZERO);
        end
        else if (code inside {[CHAR_UPPER_A:CHAR_UPPER_Z]})
        begin
            d.value = 6'(code - CHAR_UPPER_A) + UPPER_BASE;
        end
        else if (code inside {[CHAR_LOWER_A:CHAR_LOWER_Z]})
        begin
            d.value = 6'(code - CHAR_LOWER_A) + LOWER_BASE;
        end
        else
        begin
            d.is_digit = 1'b0;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

@@ rtl/b62_mac.sv @@
// byte-serial multiply-by-62 and carry unit shared by every accumulator byte
`default_nettype none

module b62_mac
    import b62_pkg::*;
(
    input  wire logic [7:0]         acc_byte,
    input  wire logic [CARRY_W-1:0] carry_in,
    output logic      [7:0]         sum_byte,
    output logic      [CARRY_W-1:0] carry_out
);

    logic [MAC_W-1:0] sum;

    // at most 255*62 + 62, so the carry stays within six bits
    assign sum       = MAC_W'(acc_byte) * MAC_W'(RADIX) + MAC_W'(carry_in);
    assign sum_byte  = sum[7:0];
    assign carry_out = sum[MAC_W-1:8];

endmodule

`default_nettype wire

@@ rtl/base62_decoder.sv @@
// top level of the streaming base62 decoder: sequencer, accumulator and register port
`default_nettype none

// Streaming base62 decoder. Characters (0-9, A-Z, a-z) arrive one beat at a
// time on the char channel, last_char marking the end of a string. Every
// accepted valid character runs one pass of the shared multiply-by-62 unit
// over the 32-byte big-endian accumulator, least significant byte first and
// one byte per cycle, so a character holds the block until its pass ends; a
// character that is ignored because the string already failed, or that fails
// it, is accepted without a pass. After the final character the check state
// compares the output length against out_capacity (capped at 32), then the
// result beats leave one per cycle, unless byte_stall holds them, through an
// output register: the leading zero bytes coming from the initial run of '0'
// characters, then the accumulator from its first nonzero byte. A failed
// string (invalid character, more than 32 characters, or too many output
// bytes) yields a single beat with out_byte 0, the error in status and
// last_byte set. char_stall is high for the whole time a character or a
// string end is being worked on. out_capacity lives at byte address 0 of the
// APB port and resets to 32; it should only be written while the block is
// idle. No clearing pass is needed after reset: a flag marks the accumulator
// as zero until the first pass rewrites every byte.
module base62_decoder
    import b62_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,

    input  wire logic        char_valid,
    output logic             char_stall,
    input  wire logic [7:0]  char_code,
    input  wire logic        last_char,

    output logic             byte_valid,
    input  wire logic        byte_stall,
    output logic      [7:0]  out_byte,
    output logic      [1:0]  status,
    output logic             last_byte
);

    state_t state_reg, state_next;

    // configuration
    logic [CAP_W-1:0] cap_reg;
    logic             cfg_sel;

    // accumulator, written one byte per cycle by the shared unit
    logic [7:0]       acc_reg [MAX_CHARS];
    logic             acc_zero_reg;

    // per-string state
    logic [CNT_W-1:0]   char_cnt_reg;
    logic [CNT_W-1:0]   lz_cnt_reg;
    logic               in_run_reg;
    status_t            err_reg;
    logic               last_reg;
    logic [CNT_W-1:0]   first_nz_reg;

    // pass and emit sequencing
    logic [IDX_W-1:0]   idx_reg;
    logic [CARRY_W-1:0] carry_reg;
    logic               zphase_reg;
    logic [CNT_W-1:0]   ecnt_reg;

    // output register
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    status_t     out_status_reg;
    logic        out_last_reg;

    // control
    logic        accept;
    logic        mul_step;
    logic        pass_end;
    logic        slot_free;
    logic        emit_fire;
    logic        emit_last;
    digit_t      digit;
    logic        start_mul;
    status_t     err_in;

    logic [7:0]         mac_in;
    logic [7:0]         mac_byte;
    logic [CARRY_W-1:0] mac_carry;

    logic [TOT_W-1:0]   total;
    logic [CAP_W-1:0]   cap_eff;

    // ---------------------------------------------------------------- apb
    assign pready  = 1'b1;
    assign cfg_sel = (paddr[2] == 1'b0);
    assign prdata  = cfg_sel ? 32'(cap_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_W'(RESULT_LIMIT);
        end
        else if (psel && penable && pwrite && pready && cfg_sel)
        begin
            cap_reg <= pwdata[CAP_W-1:0];
        end
    end

    // ---------------------------------------------------------------- input decode
    assign digit = char_to_digit(char_code);

    // what a newly accepted character does to the error code
    always_comb
    begin
        err_in    = err_reg;
        start_mul = 1'b0;
        if (err_reg == STAT_OK)
        begin
            if (char_cnt_reg >= CNT_W'(MAX_CHARS))
            begin
                err_in = STAT_TOO_LONG;
            end
            else if (!digit.is_digit)
            begin
                err_in = STAT_INVALID;
            end
            else
            begin
                start_mul = 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- shared unit
    assign mac_in = acc_zero_reg ? 8'd0 : acc_reg[idx_reg];

    b62_mac u_mac (
        .acc_byte  (mac_in),
        .carry_in  (carry_reg),
        .sum_byte  (mac_byte),
        .carry_out (mac_carry)
    );

    // ---------------------------------------------------------------- length check
    assign cap_eff = (cap_reg > CAP_W'(RESULT_LIMIT)) ? CAP_W'(RESULT_LIMIT) : cap_reg;
    assign total   = TOT_W'(lz_cnt_reg) + (TOT_W'(MAX_CHARS) - TOT_W'(first_nz_reg));

    // ---------------------------------------------------------------- fsm outputs
    assign slot_free = !out_valid_reg || !byte_stall;

    always_comb
    begin
        char_stall = 1'b1;
        mul_step   = 1'b0;
        emit_fire  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                char_stall = 1'b0;
            end
            ST_MUL:
            begin
                mul_step = 1'b1;
            end
            ST_EMIT:
            begin
                emit_fire = slot_free;
            end
            default:
            begin
                char_stall = 1'b1;
            end
        endcase
    end

    assign accept   = char_valid && !char_stall;
    assign pass_end = mul_step && (idx_reg == '0);

    // final beat of the string
    always_comb
    begin
        if (err_reg != STAT_OK)
        begin
            emit_last = 1'b1;
        end
        else if (zphase_reg)
        begin
            emit_last = ((ecnt_reg + 1'b1) == lz_cnt_reg)
                     && (first_nz_reg == CNT_W'(MAX_CHARS));
        end
        else
        begin
            emit_last = (idx_reg == IDX_W'(MAX_CHARS - 1));
        end
    end

    // ---------------------------------------------------------------- fsm next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (start_mul)
                    begin
                        state_next = ST_MUL;
                    end
                    else if (last_char)
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_MUL:
            begin
                if (pass_end)
                begin
                    state_next = last_reg ? ST_CHECK : ST_IDLE;
                end
            end
            ST_CHECK:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_fire && emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ---------------------------------------------------------------- string state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_zero_reg <= 1'b1;
            char_cnt_reg <= '0;
            lz_cnt_reg   <= '0;
            in_run_reg   <= 1'b1;
            err_reg      <= STAT_OK;
            last_reg     <= 1'b0;
            first_nz_reg <= CNT_W'(MAX_CHARS);
            idx_reg      <= '0;
            carry_reg    <= '0;
            zphase_reg   <= 1'b0;
            ecnt_reg     <= '0;
        end
        else if (accept)
        begin
            last_reg <= last_char;
            err_reg  <= err_in;
            if (start_mul)
            begin
                char_cnt_reg <= char_cnt_reg + 1'b1;
                if (in_run_reg && (char_code == CHAR_ZERO))
                begin
                    lz_cnt_reg <= lz_cnt_reg + 1'b1;
                end
                else
                begin
                    in_run_reg <= 1'b0;
                end
                // the pass starts at the least significant byte
                carry_reg    <= CARRY_W'(digit.value);
                idx_reg      <= IDX_W'(MAX_CHARS - 1);
                first_nz_reg <= CNT_W'(MAX_CHARS);
            end
        end
        else if (mul_step)
        begin
            carry_reg <= mac_carry;
            idx_reg   <= idx_reg - 1'b1;
            // moving toward the top byte, so the last nonzero seen is the first
            if (mac_byte != 8'd0)
            begin
                first_nz_reg <= CNT_W'(idx_reg);
            end
            if (pass_end)
            begin
                acc_zero_reg <= 1'b0;
            end
        end
        else if (state_reg == ST_CHECK)
        begin
            if ((err_reg == STAT_OK) && (total > TOT_W'(cap_eff)))
            begin
                err_reg <= STAT_CAPACITY;
            end
            zphase_reg <= (lz_cnt_reg != '0);
            ecnt_reg   <= '0;
            idx_reg    <= first_nz_reg[IDX_W-1:0];
        end
        else if (emit_fire)
        begin
            if (emit_last)
            begin
                // string done: back to the empty state
                acc_zero_reg <= 1'b1;
                char_cnt_reg <= '0;
                lz_cnt_reg   <= '0;
                in_run_reg   <= 1'b1;
                err_reg      <= STAT_OK;
                last_reg     <= 1'b0;
                first_nz_reg <= CNT_W'(MAX_CHARS);
                zphase_reg   <= 1'b0;
            end
            else if (zphase_reg)
            begin
                ecnt_reg <= ecnt_reg + 1'b1;
                if ((ecnt_reg + 1'b1) == lz_cnt_reg)
                begin
                    zphase_reg <= 1'b0;
                end
            end
            else
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    // accumulator bytes
    always_ff @(posedge clk)
    begin
        if (mul_step)
        begin
            acc_reg[idx_reg] <= mac_byte;
        end
    end

    // ---------------------------------------------------------------- output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!byte_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_last_reg   <= emit_last;
            out_status_reg <= err_reg;
            if ((err_reg != STAT_OK) || zphase_reg)
            begin
                out_byte_reg <= 8'd0;
            end
            else
            begin
                out_byte_reg <= acc_reg[idx_reg];
            end
        end
    end

    assign byte_valid = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign status     = out_status_reg;
    assign last_byte  = out_last_reg;

endmodule

`default_nettype wire

@@ tb/base62_checker.sv @@
// checker for the base62 decoder: follows the register port and both channels, predicts each output beat
module base62_checker
    import b62_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic [31:0] prdata,
    input  wire logic        pready,

    input  wire logic        char_valid,
    input  wire logic        char_stall,
    input  wire logic [7:0]  char_code,
    input  wire logic        last_char,

    input  wire logic        byte_valid,
    input  wire logic        byte_stall,
    input  wire logic [7:0]  out_byte,
    input  wire logic [1:0]  status,
    input  wire logic        last_byte,

    output int               fail_count,
    output int               pending
);

    localparam int REG_CAPACITY = 0;

    typedef struct packed {
        logic [7:0] data;
        status_t    stat;
        logic       fin;
    } dec_beat_t;

    dec_beat_t  decoded_beats[$];
    logic [7:0] acc_bytes [MAX_CHARS];
    int         zero_run;
    int         digit_count;
    bit         in_zero_run;
    status_t    string_err;
    logic [5:0] capacity;

    // digit of a character code, -1 outside the alphabet
    function automatic int digit_value(input logic [7:0] code);
        if (code >= CHAR_ZERO && code <= CHAR_NINE)
            return int'(code - CHAR_ZERO);
        if (code >= CHAR_UPPER_A && code <= CHAR_UPPER_Z)
            return int'(code - CHAR_UPPER_A) + int'(UPPER_BASE);
        if (code >= CHAR_LOWER_A && code <= CHAR_LOWER_Z)
            return int'(code - CHAR_LOWER_A) + int'(LOWER_BASE);
        return -1;
    endfunction

    task automatic clear_string();
        for (int i = 0; i < MAX_CHARS; i++)
            acc_bytes[i] = 8'h00;
        zero_run    = 0;
        digit_count = 0;
        in_zero_run = 1'b1;
        string_err  = STAT_OK;
    endtask

    task automatic note_mismatch(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    // one accepted character: update the accumulator, on the last one queue the beats
    task automatic decode_char(input logic [7:0] code, input logic fin);
        int        d;
        int        carry;
        int        first_nz;
        int        total;
        int        cap_eff;
        dec_beat_t b;
        if (string_err == STAT_OK)
        begin
            if (digit_count >= MAX_CHARS)
                string_err = STAT_TOO_LONG;
            else
            begin
                d = digit_value(code);
                if (d < 0)
                    string_err = STAT_INVALID;
                else
                begin
                    digit_count++;
                    if (in_zero_run && code == CHAR_ZERO)
                        zero_run++;
                    else
                        in_zero_run = 1'b0;
                    carry = d;
                    for (int i = MAX_CHARS - 1; i >= 0; i--)
                    begin
                        carry        = carry + int'(acc_bytes[i]) * RADIX;
                        acc_bytes[i] = carry[7:0];
                        carry        = carry >> 8;
                    end
                end
            end
        end
        if (!fin)
            return;
        first_nz = 0;
        while (first_nz < MAX_CHARS && acc_bytes[first_nz] == 8'h00)
            first_nz++;
        total   = zero_run + MAX_CHARS - first_nz;
        cap_eff = (int'(capacity) > RESULT_LIMIT) ? RESULT_LIMIT : int'(capacity);
        if (string_err == STAT_OK && total > cap_eff)
            string_err = STAT_CAPACITY;
        if (string_err != STAT_OK)
        begin
            b.data = 8'h00;
            b.stat = string_err;
            b.fin  = 1'b1;
            decoded_beats.push_back(b);
        end
        else
        begin
            for (int k = 0; k < total; k++)
            begin
                if (k < zero_run)
                    b.data = 8'h00;
                else
                    b.data = acc_bytes[first_nz + k - zero_run];
                b.stat = STAT_OK;
                b.fin  = (k == total - 1);
                decoded_beats.push_back(b);
            end
        end
        clear_string();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        dec_beat_t b;
        if (!rst_n)
        begin
            clear_string();
            capacity   = 6'd32;
            fail_count = 0;
            decoded_beats.delete();
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (int'(paddr >> 2) == REG_CAPACITY)
                        capacity = pwdata[5:0];
                end
                else if (int'(paddr >> 2) == REG_CAPACITY && prdata[5:0] !== capacity)
                    note_mismatch($sformatf("out_capacity read exp %0d got %0d",
                                            capacity, prdata[5:0]));
            end
            // beats leaving now belong to strings ended earlier, so check before queuing
            if (byte_valid && !byte_stall)
            begin
                if (decoded_beats.size() == 0)
                    note_mismatch($sformatf("beat with nothing expected: byte %02h status %0d last %0b",
                                            out_byte, status, last_byte));
                else
                begin
                    b = decoded_beats.pop_front();
                    if (out_byte !== b.data || status !== b.stat || last_byte !== b.fin)
                        note_mismatch($sformatf(
                            "exp byte %02h status %0d last %0b, got byte %02h status %0d last %0b",
                            b.data, b.stat, b.fin, out_byte, status, last_byte));
                end
            end
            if (char_valid && !char_stall)
                decode_char(char_code, last_char);
            pending <= decoded_beats.size();
        end
    end

endmodule

@@ tb/base62_decoder_tb.sv @@
// testbench top for the base62 decoder: clock, reset, stimulus and verdict
module base62_decoder_tb;
    import b62_pkg::*;

    // register map, byte addresses on the register port
    localparam logic [2:0] ADDR_CAPACITY = 3'd0;
    localparam logic [2:0] ADDR_SPARE    = 3'd4;

    localparam int IDLE_PCT       = 12;
    localparam int PHASE_ITEMS    = 46;
    localparam int NUM_PHASES     = 8;
    // time for the block to finish a character, plus check and output
    localparam int SETTLE_CYCLES  = 40;
    // no beat for this long means the block hung
    localparam int WATCHDOG_LIMIT = 3000;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;

    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [2:0]  paddr      = '0;
    logic [31:0] pwdata     = '0;
    logic [31:0] prdata;
    logic        pready;

    logic        char_valid = 1'b0;
    logic        char_stall;
    logic [7:0]  char_code  = '0;
    logic        last_char  = 1'b0;

    logic        byte_valid;
    logic        byte_stall = 1'b0;
    logic [7:0]  out_byte;
    logic [1:0]  status;
    logic        last_byte;

    int          fail_count;
    int          pending;
    int          items_sent   = 0;
    int          quiet_cycles = 0;
    // random idling on both channels; cleared for one phase to get a stretch at full rate
    bit          idle_on      = 1'b1;

    // characters of the string about to be sent
    logic [7:0]  str_buf[$];

    base62_decoder u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_code  (char_code),
        .last_char  (last_char),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .out_byte   (out_byte),
        .status     (status),
        .last_byte  (last_byte)
    );

    base62_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_code  (char_code),
        .last_char  (last_char),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .out_byte   (out_byte),
        .status     (status),
        .last_byte  (last_byte),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver side: random stall, none while idling is off
    always @(posedge clk)
        byte_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);

    // watchdog: counts cycles in which neither channel moves a beat
    always @(posedge clk)
    begin
        if (!rst_n || (char_valid && !char_stall) || (byte_valid && !byte_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // random character from the 62-symbol alphabet
    function automatic logic [7:0] rand_alpha();
        int r;
        r = $urandom_range(61);
        if (r < int'(UPPER_BASE))
            return CHAR_ZERO + 8'(r);
        if (r < int'(LOWER_BASE))
            return CHAR_UPPER_A + 8'(r - int'(UPPER_BASE));
        return CHAR_LOWER_A + 8'(r - int'(LOWER_BASE));
    endfunction

    // random code outside the alphabet, about two thirds of them with bit 7 set
    function automatic logic [7:0] rand_bad();
        logic [7:0] c;
        c = CHAR_ZERO;
        while ((c >= CHAR_ZERO && c <= CHAR_NINE) ||
               (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
               (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z))
            c = 8'($urandom_range(255));
        return c;
    endfunction

    task automatic load_text(input string s);
        for (int i = 0; i < s.len(); i++)
            str_buf.push_back(s[i]);
    endtask

    // one character beat; valid stays high afterwards so back-to-back beats need no gap
    task automatic send_char(input logic [7:0] code, input logic fin);
        if (idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            char_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        char_valid <= 1'b1;
        char_code  <= code;
        last_char  <= fin;
        @(posedge clk);
        while (char_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // send the buffered string, last_char on its final character
    task automatic send_buf();
        for (int i = 0; i < str_buf.size(); i++)
            send_char(str_buf[i], i == str_buf.size() - 1);
        str_buf.delete();
    endtask

    // stop sending until every predicted beat is out; settle lets the block go idle
    task automatic drain(input bit settle);
        char_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        if (settle)
            repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // setup cycle then access cycle
    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // the checker compares the returned value
    task automatic reg_read(input logic [2:0] addr);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int         phase_start;
        int         len;
        int         zeros;
        int         kind;
        int         target;
        logic [5:0] cap_value;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // capacity should read back its reset value of 32
        reg_read(ADDR_CAPACITY);

        // directed strings
        load_text("0");                                        // single zero byte
        send_buf();
        load_text("00");                                       // all zero digits
        send_buf();
        load_text("0z");                                       // leading zero then top digit
        send_buf();
        load_text("AZaz");                                     // letter range edges
        send_buf();
        load_text("9");
        send_buf();
        str_buf.push_back(8'h00);                              // invalid first, then a digit
        load_text("A");
        send_buf();
        str_buf.push_back(8'hff);                              // invalid code on the last char
        send_buf();
        load_text("5");                                        // high-half code, first error wins
        str_buf.push_back(8'h80);
        load_text("{");
        send_buf();
        load_text("/:");                                       // just outside the digits
        send_buf();
        load_text("@[");                                       // just outside the letters
        str_buf.push_back(8'h60);
        send_buf();

        // random part, one capacity setting per phase
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase > 0)
            begin
                drain(1'b1);
                case (phase)
                    1:       cap_value = 6'd0;                 // every string fails
                    2:       cap_value = 6'd1;
                    3:       cap_value = 6'd63;                // saturates at 32
                    4:       cap_value = 6'd2;
                    5:       cap_value = 6'd33;
                    6:       cap_value = 6'($urandom_range(1, 32));
                    default: cap_value = 6'd32;
                endcase
                // junk in the upper bits must not matter
                reg_write(ADDR_CAPACITY, ($urandom() & ~32'h3f) | 32'(cap_value));
                // the spare address is not a register, the capacity must survive it
                reg_write(ADDR_SPARE, $urandom());
                reg_read(ADDR_CAPACITY);
            end
            // one phase at full rate on both sides
            idle_on <= (phase != 5);

            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                kind = $urandom_range(99);
                if (kind < 6)
                begin
                    // noise: any codes, mostly outside the alphabet
                    repeat ($urandom_range(1, 3))
                        str_buf.push_back(8'($urandom_range(255)));
                end
                else
                begin
                    // well-formed string, mostly short, sometimes the longest allowed
                    if ($urandom_range(9) == 0)
                        len = $urandom_range(1) ? MAX_CHARS : $urandom_range(20, MAX_CHARS);
                    else
                        len = $urandom_range(1, 8);
                    zeros = ($urandom_range(3) == 0) ? $urandom_range(0, len) : 0;
                    for (int i = 0; i < len; i++)
                        str_buf.push_back((i < zeros) ? CHAR_ZERO : rand_alpha());
                    if (kind < 14)
                    begin
                        // run past the character limit
                        target = MAX_CHARS + $urandom_range(1, 3);
                        while (str_buf.size() < target)
                            str_buf.push_back(rand_alpha());
                    end
                    else if (kind < 26)
                        str_buf[$urandom_range(len - 1)] = rand_bad();
                end
                send_buf();
                // now and then hold off until the output side has caught up
                if ($urandom_range(9) == 0)
                    drain(1'b0);
            end
        end

        drain(1'b1);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
